/* rtl/core/ins_sort_pkg.sv */
// ins_sort_pkg: shared types and constants of the insertion sorter
// used by insertion_sorter_core and its port checker; no dependencies
`default_nettype none

package ins_sort_pkg;

    // width of one sorted value
    localparam int DATA_W = 32;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_SHIFT   = 5'b00010,
        ST_PUT     = 5'b00100,
        ST_EMIT_RD = 5'b01000,
        ST_EMIT    = 5'b10000
    } t_state;

endpackage

`default_nettype wire

/* rtl/core/insertion_sorter_core.sv */
// insertion_sorter_core: batch insertion sort of signed values over one store memory
// depends on ins_sort_pkg
`default_nettype none

// Takes a batch of signed 32-bit values, one per input item, and keeps them in a
// sorted store of MAX_ITEMS entries. Each value is placed by walking down from the
// top of the store through one compare-and-move unit, one entry per cycle: every
// entry strictly greater than the new value moves up one place, so equal values keep
// their arrival order. An item is written at once, or dropped, when the store is
// empty or full; otherwise it walks through ST_SHIFT (and ST_PUT if it is the
// smallest), and o_ready is low while it works. The item with i_batch_end high
// closes the batch: after a read in ST_EMIT_RD the store streams out in ascending
// order, one result per cycle while the sink takes them, the last one marked by
// o_final_res. Values that arrive while the store is full (the closing one too) are
// dropped, and every result of that batch then shows o_overflow. After the last
// result the store is empty again. The result sits in an output register, so a new
// item can be accepted while the final result of the previous batch still waits.
module insertion_sorter_core #(
    parameter int MAX_ITEMS = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    i_valid,
    output logic                                         o_ready,
    input  wire logic signed [ins_sort_pkg::DATA_W-1:0]  i_value,
    input  wire logic                                    i_batch_end,
    output logic                                         o_valid,
    input  wire logic                                    i_ready,
    output logic signed [ins_sort_pkg::DATA_W-1:0]       o_sorted_value,
    output logic                                         o_final_res,
    output logic                                         o_overflow
);
    import ins_sort_pkg::*;

    // index into the store, and entry count that can also hold MAX_ITEMS itself
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ITEMS);

    // sorted store, one write and one registered read per cycle
    logic signed [DATA_W-1:0] r_mem [MAX_ITEMS];
    logic signed [DATA_W-1:0] r_rd_data;

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_pos, n_pos;       // hole where the new value may go
    logic [AW-1:0]            r_idx, n_idx;       // next entry to emit
    logic [CW-1:0]            r_count, n_count;
    logic                     r_dropped, n_dropped;
    logic signed [DATA_W-1:0] r_key, n_key;
    logic                     r_last, n_last;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_value;
    logic                     r_out_final;
    logic                     r_out_ovf;

    logic                     w_in_acc;
    logic                     w_load;
    logic                     w_wr_en;
    logic [AW-1:0]            w_wr_addr;
    logic signed [DATA_W-1:0] w_wr_data;
    logic [AW-1:0]            w_rd_addr;
    logic                     w_emit_last;

    assign o_ready        = (r_state == ST_IDLE);
    assign w_in_acc       = i_valid && o_ready;
    assign w_emit_last    = ((CW'(r_idx) + CW'(1)) == r_count);

    assign o_valid        = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;
    assign o_overflow     = r_out_ovf;

    // sequencer: insertion walk, then streaming of the store on batch end
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_idx     = r_idx;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_key     = r_key;
        n_last    = r_last;
        w_wr_en   = 1'b0;
        w_wr_addr = r_pos;
        w_wr_data = r_key;
        w_rd_addr = r_pos - AW'(1);
        w_load    = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_key  = i_value;
                    n_last = i_batch_end;
                    n_idx  = '0;
                    if (r_count == '0) begin
                        // empty store: value goes straight to the bottom
                        w_wr_en   = 1'b1;
                        w_wr_addr = '0;
                        w_wr_data = i_value;
                        n_count   = CW'(1);
                        n_state   = i_batch_end ? ST_EMIT_RD : ST_IDLE;
                    end else if (r_count < FULL_CNT) begin
                        // start the walk at the top, fetch the highest entry
                        n_pos     = r_count[AW-1:0];
                        w_rd_addr = AW'(r_count - CW'(1));
                        n_state   = ST_SHIFT;
                    end else begin
                        // store full: item dropped
                        n_dropped = 1'b1;
                        n_state   = i_batch_end ? ST_EMIT_RD : ST_IDLE;
                    end
                end
            end
            ST_SHIFT: begin
                w_wr_en = 1'b1;
                if (r_rd_data > r_key) begin
                    // move the larger entry up, fetch the one below it
                    w_wr_data = r_rd_data;
                    n_pos     = r_pos - AW'(1);
                    w_rd_addr = r_pos - AW'(2);
                    if (r_pos == AW'(1)) begin
                        n_state = ST_PUT;
                    end
                end else begin
                    w_wr_data = r_key;
                    n_count   = r_count + CW'(1);
                    n_state   = r_last ? ST_EMIT_RD : ST_IDLE;
                end
            end
            ST_PUT: begin
                // new value is the smallest so far
                w_wr_en   = 1'b1;
                w_wr_data = r_key;
                n_count   = r_count + CW'(1);
                n_state   = r_last ? ST_EMIT_RD : ST_IDLE;
            end
            ST_EMIT_RD: begin
                w_rd_addr = r_idx;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                w_rd_addr = r_idx;
                if (!r_out_valid || i_ready) begin
                    w_load = 1'b1;
                    if (w_emit_last) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end else begin
                        n_idx     = r_idx + AW'(1);
                        w_rd_addr = r_idx + AW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // store memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
        end
    end

    // working payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_idx  <= n_idx;
        r_key  <= n_key;
        r_last <= n_last;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value <= r_rd_data;
            r_out_final <= w_emit_last;
            r_out_ovf   <= r_dropped;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ins_sort_checker.sv */
// ins_sort_checker: port-level assertions for insertion_sorter_core, with its bind
// depends on ins_sort_pkg
`default_nettype none

module ins_sort_checker (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic                                    o_ready,
    input  wire logic                                    o_valid,
    input  wire logic                                    i_ready,
    input  wire logic signed [ins_sort_pkg::DATA_W-1:0]  o_sorted_value,
    input  wire logic                                    o_final_res,
    input  wire logic                                    o_overflow
);
    import ins_sort_pkg::*;

    // results of one batch come out in ascending order
    a_ascending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_final_res) |=>
            (!o_valid || (o_sorted_value >= $past(o_sorted_value))))
        else $error("results of a batch not in ascending order");

    // overflow flag is the same on every result of a batch
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_final_res) |=> $stable(o_overflow))
        else $error("overflow flag changed within a batch");

    // no new item taken while a batch is still being emitted
    a_busy_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_final_res) |-> !o_ready)
        else $error("input ready in the middle of a batch");

    // handshake outputs always known out of reset
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown({o_valid, o_ready}))
        else $error("handshake output unknown");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_sorted_value)))
        else $error("stalled result dropped or changed");

endmodule

bind insertion_sorter_core ins_sort_checker u_ins_sort_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sorted_value (o_sorted_value),
    .o_final_res    (o_final_res),
    .o_overflow     (o_overflow)
);

`default_nettype wire
